[rtl/mhc_pkg.sv]
// Shared types, constants and digit functions for the 3-D Morton/Hilbert converter.
// No dependencies; used by mhc_cell and morton_hilbert_3d_convert.
`default_nettype none

package mhc_pkg;

	localparam int CODE_W   = 30;
	localparam int DIGITS   = CODE_W / 3;
	localparam int LVL_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS    = 2'd1;

	// packed lookup tables; the code and sign tables hold one nibble per entry
	localparam logic [31:0] MCODE_TABLE = 32'h20212021;
	localparam logic [8:0]  ROT_TABLE   = 9'h049;
	localparam logic [31:0] SIGN_TABLE  = 32'h53560300;

	typedef logic [CODE_W-1:0] code_t;

	// per-item traveling state along the cell chain
	typedef struct packed {
		logic       vld;
		code_t      code;
		logic [2:0] hd;
		logic [1:0] rot;
		logic [2:0] sgn;
	} mhc_lane_t;

	// static configuration seen by every cell
	typedef struct packed {
		logic             to_morton;
		logic [LVL_W-1:0] nlev;
	} mhc_cfg_t;

	function automatic logic [1:0] sel_of(input logic [2:0] hd);
		return MCODE_TABLE[{hd, 2'b00} +: 2];
	endfunction

	function automatic logic [2:0] sign_of(input logic [2:0] hd);
		return SIGN_TABLE[{hd, 2'b00} +: 3];
	endfunction

	function automatic logic [1:0] rot_of(input logic [2:0] amt);
		return ROT_TABLE[amt +: 2];
	endfunction

	// rotate a 3-bit digit right by r within 3 bits
	function automatic logic [2:0] rot3(input logic [2:0] d, input logic [1:0] r);
		logic [5:0] dd;
		dd = {d, d} >> r;
		return dd[2:0];
	endfunction

	// Hilbert to Morton pre-step: per triple b0 ^= b1, then b1 ^= b2
	function automatic code_t tri_pre(input code_t c);
		code_t r;
		r = c;
		for (int i = 0; i < DIGITS; i++) begin
			r[3*i]   = c[3*i] ^ c[3*i+1];
			r[3*i+1] = c[3*i+1] ^ c[3*i+2];
		end
		return r;
	endfunction

	// Morton to Hilbert post-step: per triple b1 ^= b2, then b0 ^= b1
	function automatic code_t tri_post(input code_t c);
		code_t r;
		r = c;
		for (int i = 0; i < DIGITS; i++) begin
			r[3*i+1] = c[3*i+1] ^ c[3*i+2];
			r[3*i]   = c[3*i] ^ c[3*i+1] ^ c[3*i+2];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/mhc_cell.sv]
// One level cell of the converter chain: updates rotation and sign, rewrites one digit.
// Depends on mhc_pkg.
`default_nettype none

module mhc_cell #(
	parameter int K = 0
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire mhc_pkg::mhc_cfg_t   cfg,
	input  wire mhc_pkg::mhc_lane_t  lane_in,
	output mhc_pkg::mhc_lane_t       lane_s1
);
	import mhc_pkg::*;

	logic             active;
	logic [LVL_W-1:0] j;
	logic [1:0]       sel;
	logic [2:0]       amt;
	logic [1:0]       rot_n;
	logic [5:0]       sgn6;
	logic [2:0]       sgn_n;
	logic [2:0]       d;
	logic [2:0]       nd;
	mhc_lane_t        nxt;

	// this cell handles digit nlev-2-K when that digit exists
	assign active = (LVL_W'(K + 1) < cfg.nlev);
	assign j      = cfg.nlev - LVL_W'(K + 2);

	// derive new rotation, sign and digit
	always_comb begin
		sel  = sel_of(lane_in.hd);
		amt  = cfg.to_morton ? (3'd4 - {1'b0, lane_in.rot} + {1'b0, sel})
		                     : (3'd4 - {1'b0, lane_in.rot} - {1'b0, sel});
		rot_n = rot_of(amt);
		sgn6  = {lane_in.sgn, lane_in.sgn} >> sel;
		sgn_n = sgn6[2:0] ^ sign_of(lane_in.hd);
		d = 3'd0;
		for (int i = 0; i < DIGITS; i++) begin
			if (LVL_W'(i) == j) begin
				d = lane_in.code[3*i +: 3];
			end
		end
		nd = cfg.to_morton ? rot3(d ^ sgn_n, rot_n) : (rot3(d, rot_n) ^ sgn_n);
		nxt = lane_in;
		if (active) begin
			nxt.rot = rot_n;
			nxt.sgn = sgn_n;
			nxt.hd  = cfg.to_morton ? d : nd;
			for (int i = 0; i < DIGITS; i++) begin
				if (LVL_W'(i) == j) begin
					nxt.code[3*i +: 3] = nd;
				end
			end
		end
	end

	// advance valid and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
		end else begin
			lane_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/morton_hilbert_3d_convert.sv]
// Each accepted item passes the input stage, the level cells and the output stage before done pulses.
// Throughput: one item per cycle while busy is low; one input stage, MAX_LEVELS-1 level cells, one output stage.
// Reset: arst_n clears valid bits and loads direction 0, levels 10; busy stays high and
// cfg_ready low for the first cycle after reset. The receiver cannot stall; done is a strobe.
// Depends on mhc_pkg and mhc_cell.
`default_nettype none

module morton_hilbert_3d_convert #(
	parameter int MAX_LEVELS = 10
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [mhc_pkg::CODE_W-1:0]          code_in,
	output logic                                done,
	output logic [mhc_pkg::CODE_W-1:0]          code_out,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [mhc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [mhc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mhc_pkg::*;

	localparam int NCELL = MAX_LEVELS - 1;

	logic             busy_q;
	logic             direction_q;
	logic [LVL_W-1:0] levels_q;
	mhc_cfg_t         cfg;
	code_t            pre_code;
	logic [LVL_W-1:0] top_j;
	logic [2:0]       top_d;
	mhc_lane_t        in_s1;
	mhc_lane_t        lane [NCELL+1];
	logic             done_q;
	code_t            code_out_q;

	// hold off items and writes out of reset until the first clock edge clears busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			levels_q    <= LVL_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIRECTION: direction_q <= cfg_data[0];
				REG_LEVELS:    levels_q    <= cfg_data[LVL_W-1:0];
				default:       ;
			endcase
		end
	end

	// clamp level count to the chain length
	always_comb begin
		cfg.to_morton = direction_q;
		cfg.nlev      = (levels_q > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels_q;
	end

	// input stage: pre-step (to-Morton direction only) and top digit
	always_comb begin
		pre_code = direction_q ? tri_pre(code_in) : code_in;
		top_j    = cfg.nlev - LVL_W'(1);
		top_d    = 3'd0;
		for (int i = 0; i < DIGITS; i++) begin
			if (LVL_W'(i) == top_j) begin
				top_d = pre_code[3*i +: 3];
			end
		end
	end

	// register the item entering the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else begin
			in_s1.vld  <= start && !busy_q;
			in_s1.code <= pre_code;
			in_s1.hd   <= top_d;
			in_s1.rot  <= 2'd0;
			in_s1.sgn  <= 3'd0;
		end
	end

	assign lane[0] = in_s1;

	// chain of level cells
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		mhc_cell #(.K(k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg),
			.lane_in (lane[k]),
			.lane_s1 (lane[k+1])
		);
	end

	// output stage: post-step (to-Hilbert direction only) and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lane[NCELL].vld;
		end
	end

	always_ff @(posedge clk) begin
		code_out_q <= direction_q ? lane[NCELL].code : tri_post(lane[NCELL].code);
	end

	assign done     = done_q;
	assign code_out = code_out_q;

	// every accepted item comes out as a done strobe at the end of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(MAX_LEVELS+1) done)
		else $error("item accepted but no result after pipeline latency");

	// no result without an item accepted at the matching edge
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(MAX_LEVELS+1) !done)
		else $error("result strobe without a matching item");

	// configuration is not accepted while busy after reset
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(direction_q) && $stable(levels_q))
		else $error("configuration changed while busy");

endmodule

`default_nettype wire
